>>> rtl/core/sgcp_pkg.sv
// Package for the serial gain command parser: shared types, codes and constants.
`timescale 1ns / 1ps

package sgcp_pkg;

  localparam int unsigned LineBufferBytesDef = 32;

  localparam int unsigned CharW  = 8;
  localparam int unsigned TgtW   = 2;
  localparam int unsigned ValueW = 32;
  localparam int unsigned AccW   = 32;

  // The magnitude is clamped at 2^31 so that the most negative value survives.
  localparam logic [AccW-1:0] MagCap = 32'h8000_0000;
  localparam logic [AccW-1:0] PosMax = 32'h7FFF_FFFF;

  localparam logic [CharW-1:0] ChLf    = 8'd10;
  localparam logic [CharW-1:0] ChCr    = 8'd13;
  localparam logic [CharW-1:0] ChNul   = 8'd0;
  localparam logic [CharW-1:0] ChTab   = 8'd9;
  localparam logic [CharW-1:0] ChVt    = 8'd11;
  localparam logic [CharW-1:0] ChFf    = 8'd12;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChEq    = 8'h3D;
  localparam logic [CharW-1:0] ChK     = 8'h6B;
  localparam logic [CharW-1:0] ChT     = 8'h74;
  localparam logic [CharW-1:0] ChP     = 8'h70;
  localparam logic [CharW-1:0] ChD     = 8'h64;
  localparam logic [CharW-1:0] ChH     = 8'h68;

  // Prefix mask bits: one per command still matching.
  localparam int unsigned PfxKp = 0;
  localparam int unsigned PfxKd = 1;
  localparam int unsigned PfxTh = 2;

  localparam logic [TgtW-1:0] TgtKp = 2'd0;
  localparam logic [TgtW-1:0] TgtKd = 2'd1;
  localparam logic [TgtW-1:0] TgtTh = 2'd2;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [2:0]      prefix;
    phase_t          phase;
    logic            neg;
    logic [AccW-1:0] acc;
    logic            ended;
  } parse_state_t;

  typedef struct packed {
    logic              valid;
    logic [TgtW-1:0]   target;
    logic [ValueW-1:0] value;
  } parse_result_t;

endpackage

>>> rtl/core/sgcp_step.sv
// Next-state logic of the parser for one received word.
`timescale 1ns / 1ps

module sgcp_step #(
  parameter int unsigned LINE_BUFFER_BYTES = sgcp_pkg::LineBufferBytesDef,
  localparam int unsigned LenW = $clog2(LINE_BUFFER_BYTES)
) (
  input  logic [LenW-1:0]              len,
  input  sgcp_pkg::parse_state_t       st,
  input  logic [sgcp_pkg::CharW-1:0]   ch,
  output logic [LenW-1:0]              len_nxt,
  output sgcp_pkg::parse_state_t       st_nxt,
  output sgcp_pkg::parse_result_t      res
);

  localparam logic [LenW-1:0] LenLimit = LenW'(LINE_BUFFER_BYTES - 1);
  localparam logic [LenW-1:0] LenPfx   = LenW'(3);
  localparam logic [LenW-1:0] LenOne   = LenW'(1);
  localparam int unsigned     WideW    = sgcp_pkg::AccW + 4;

  sgcp_pkg::parse_state_t clr;
  logic                   is_eol;
  logic                   is_digit;
  logic                   is_blank;
  logic                   ended_n;
  logic [2:0]             pfx_bits;
  logic [WideW-1:0]       acc_wide;
  logic [WideW-1:0]       acc_mul;
  logic [sgcp_pkg::AccW-1:0] acc_sat;

  assign clr.prefix = 3'b000;
  assign clr.phase  = sgcp_pkg::PH_SKIP;
  assign clr.neg    = 1'b0;
  assign clr.acc    = '0;
  assign clr.ended  = 1'b0;

  assign is_eol   = (ch == sgcp_pkg::ChLf) || (ch == sgcp_pkg::ChCr);
  assign is_digit = (ch >= sgcp_pkg::ChZero) && (ch <= sgcp_pkg::ChNine);
  assign is_blank = (ch == sgcp_pkg::ChSpace) || (ch == sgcp_pkg::ChTab) ||
                    (ch == sgcp_pkg::ChVt) || (ch == sgcp_pkg::ChFf);
  assign ended_n  = st.ended || (ch == sgcp_pkg::ChNul);

  // Times ten as two shifts and an add, plus the new digit.
  assign acc_wide = {4'b0000, st.acc};
  assign acc_mul  = (acc_wide << 3) + (acc_wide << 1) +
                    {{(WideW - 4){1'b0}}, ch[3:0]};
  assign acc_sat  = (acc_mul > {4'b0000, sgcp_pkg::MagCap}) ? sgcp_pkg::MagCap
                                                            : acc_mul[sgcp_pkg::AccW-1:0];

  always_comb begin
    pfx_bits = 3'b000;
    if (len == '0) begin
      if (ch == sgcp_pkg::ChK) begin
        pfx_bits = 3'b011;
      end else if (ch == sgcp_pkg::ChT) begin
        pfx_bits = 3'b100;
      end
    end else if (len == LenOne) begin
      pfx_bits[sgcp_pkg::PfxKp] = (ch == sgcp_pkg::ChP);
      pfx_bits[sgcp_pkg::PfxKd] = (ch == sgcp_pkg::ChD);
      pfx_bits[sgcp_pkg::PfxTh] = (ch == sgcp_pkg::ChH);
      pfx_bits = pfx_bits & st.prefix;
    end else if (ch == sgcp_pkg::ChEq) begin
      pfx_bits = st.prefix;
    end
  end

  always_comb begin
    len_nxt    = len;
    st_nxt     = st;
    res.valid  = 1'b0;
    res.target = sgcp_pkg::TgtTh;
    res.value  = st.neg ? ('0 - st.acc)
                        : ((st.acc > sgcp_pkg::PosMax) ? sgcp_pkg::PosMax : st.acc);
    if (st.prefix[sgcp_pkg::PfxKp]) begin
      res.target = sgcp_pkg::TgtKp;
    end else if (st.prefix[sgcp_pkg::PfxKd]) begin
      res.target = sgcp_pkg::TgtKd;
    end

    if (len >= LenLimit) begin
      // A full line drops this word and starts over.
      len_nxt = '0;
      st_nxt  = clr;
    end else if (is_eol) begin
      res.valid = (len >= LenPfx) && (st.prefix != 3'b000);
      len_nxt   = '0;
      st_nxt    = clr;
    end else begin
      st_nxt.ended = ended_n;
      len_nxt      = len + LenOne;
      if (len < LenPfx) begin
        st_nxt.prefix = ended_n ? 3'b000 : pfx_bits;
      end else if (!ended_n && (st.prefix != 3'b000) && (st.phase != sgcp_pkg::PH_DONE)) begin
        if ((st.phase == sgcp_pkg::PH_SKIP) && is_blank) begin
          st_nxt.phase = sgcp_pkg::PH_SKIP;
        end else if ((st.phase == sgcp_pkg::PH_SKIP) &&
                     ((ch == sgcp_pkg::ChPlus) || (ch == sgcp_pkg::ChMinus))) begin
          st_nxt.neg   = (ch == sgcp_pkg::ChMinus);
          st_nxt.phase = sgcp_pkg::PH_DIGITS;
        end else if (is_digit) begin
          st_nxt.acc   = acc_sat;
          st_nxt.phase = sgcp_pkg::PH_DIGITS;
        end else begin
          st_nxt.phase = sgcp_pkg::PH_DONE;
        end
      end
    end
  end

endmodule

>>> rtl/core/serial_gain_command_parser.sv
// Top level of the serial gain command parser.
`timescale 1ns / 1ps

// Parses kp=N, kd=N and th=N lines from a stream of received characters, one
// word per cycle. Each word is captured in an input register. From there it
// updates the line state, and a finished line's result is loaded into the
// output register. So out_valid rises once the line end has left the input
// register, unless an earlier result is still waiting there. The input side
// keeps taking one word per cycle while the output register is free or being
// drained. It holds off only while a result waits.
// Lines reaching LINE_BUFFER_BYTES-1 characters drop the next word and restart.
module serial_gain_command_parser #(
  parameter int unsigned LINE_BUFFER_BYTES = sgcp_pkg::LineBufferBytesDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sgcp_pkg::CharW-1:0]        in_rx_char,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sgcp_pkg::TgtW-1:0]         out_target,
  output logic signed [sgcp_pkg::ValueW-1:0] out_value
);

  localparam int unsigned LenW = $clog2(LINE_BUFFER_BYTES);

  logic                          ch_vld_r;
  logic [sgcp_pkg::CharW-1:0]    ch_r;
  logic [LenW-1:0]               len_r;
  logic [LenW-1:0]               len_nxt;
  sgcp_pkg::parse_state_t        st_r;
  sgcp_pkg::parse_state_t        st_nxt;
  sgcp_pkg::parse_result_t       res;
  logic                          out_vld_r;
  logic [sgcp_pkg::TgtW-1:0]     out_tgt_r;
  logic [sgcp_pkg::ValueW-1:0]   out_val_r;
  logic                          adv;

  assign adv      = ch_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !ch_vld_r || adv;

  sgcp_step #(
    .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
  ) u_step (
    .len    (len_r),
    .st     (st_r),
    .ch     (ch_r),
    .len_nxt(len_nxt),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      len_r        <= '0;
      st_r.prefix  <= 3'b000;
      st_r.phase   <= sgcp_pkg::PH_SKIP;
      st_r.neg     <= 1'b0;
      st_r.acc     <= '0;
      st_r.ended   <= 1'b0;
    end else begin
      if (in_ready) begin
        ch_vld_r <= in_valid;
      end
      if (adv) begin
        len_r     <= len_nxt;
        st_r      <= st_nxt;
        out_vld_r <= res.valid;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r <= in_rx_char;
    end
    if (adv && res.valid) begin
      out_tgt_r <= res.target;
      out_val_r <= res.value;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_target = out_tgt_r;
  assign out_value  = out_val_r;

endmodule

>>> rtl/core/sgcp_checker.sv
// Port-level assertions for the serial gain command parser, with its bind.
`timescale 1ns / 1ps

module sgcp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [sgcp_pkg::CharW-1:0]        in_rx_char,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sgcp_pkg::TgtW-1:0]         out_target,
  input logic signed [sgcp_pkg::ValueW-1:0] out_value
);

  // A stalled result word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_target) && $stable(out_value)))
    else $error("result word changed while stalled");

  a_tgt_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_target == sgcp_pkg::TgtKp) || (out_target == sgcp_pkg::TgtKd) ||
                   (out_target == sgcp_pkg::TgtTh)))
    else $error("result target has an unused code");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result follows an accepted line end.
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready &&
      ((in_rx_char == sgcp_pkg::ChLf) || (in_rx_char == sgcp_pkg::ChCr)), 2))
    else $error("result without a preceding line end");

endmodule

bind serial_gain_command_parser sgcp_checker u_sgcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_rx_char(in_rx_char),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_target(out_target),
  .out_value (out_value)
);

>>> verif/gain_parser_check_pkg.sv
// Scoreboard for the serial gain command parser, with its own line predictor.
`timescale 1ns / 1ps

package gain_parser_check_pkg;

  import sgcp_pkg::*;

  class setting_scoreboard;

    typedef struct packed {
      logic [TgtW-1:0]          target;
      logic signed [ValueW-1:0] value;
    } setting_t;

    setting_t expected_settings[$];

    // Line state, kept the way the parser walks one line.
    int unsigned     line_limit;
    int unsigned     line_len;
    logic [2:0]      prefix;
    phase_t          phase;
    logic            neg;
    logic [AccW-1:0] acc;
    logic            ended;

    int unsigned chars_noted;
    int unsigned settings_checked;
    int unsigned target_count[3];
    int unsigned limit_values;
    int unsigned failures;

    function new(int unsigned line_bytes);
      line_limit = line_bytes - 1;
      chars_noted = 0;
      settings_checked = 0;
      target_count = '{0, 0, 0};
      limit_values = 0;
      failures = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len = 0;
      prefix = 3'b000;
      phase = PH_SKIP;
      neg = 1'b0;
      acc = '0;
      ended = 1'b0;
    endfunction

    // Runs one accepted word through the predictor and queues any setting it completes.
    function void note_char(logic [CharW-1:0] c);
      logic [63:0] next_mag;
      logic [2:0]  mask;
      logic        taken;
      setting_t    s;
      chars_noted++;
      if (line_len >= line_limit) begin
        // A full line swallows this word, whatever it is, and starts over.
        clear_line();
        return;
      end
      if (c == ChLf || c == ChCr) begin
        if (line_len >= 3 && prefix != 3'b000) begin
          s.target = prefix[PfxKp] ? TgtKp : (prefix[PfxKd] ? TgtKd : TgtTh);
          if (neg) begin
            s.value = 0 - acc;
          end else begin
            s.value = (acc > PosMax) ? PosMax : acc;
          end
          if (acc >= MagCap) limit_values++;
          expected_settings.push_back(s);
        end
        clear_line();
        return;
      end
      if (c == ChNul) ended = 1'b1;
      if (line_len < 3) begin
        mask = 3'b000;
        if (!ended) begin
          case (line_len)
            0: begin
              if (c == ChK) begin
                mask[PfxKp] = 1'b1;
                mask[PfxKd] = 1'b1;
              end else if (c == ChT) begin
                mask[PfxTh] = 1'b1;
              end
            end
            1: begin
              mask[PfxKp] = (c == ChP);
              mask[PfxKd] = (c == ChD);
              mask[PfxTh] = (c == ChH);
              mask = mask & prefix;
            end
            default: begin
              if (c == ChEq) mask = prefix;
            end
          endcase
        end
        prefix = mask;
      end else if (!ended && prefix != 3'b000 && phase != PH_DONE) begin
        taken = 1'b0;
        if (phase == PH_SKIP) begin
          if (c == ChSpace || c == ChTab || c == ChVt || c == ChFf) begin
            taken = 1'b1;
          end else if (c == ChPlus || c == ChMinus) begin
            neg = (c == ChMinus);
            phase = PH_DIGITS;
            taken = 1'b1;
          end else begin
            phase = PH_DIGITS;
          end
        end
        if (!taken && phase == PH_DIGITS) begin
          if (c >= ChZero && c <= ChNine) begin
            next_mag = 64'(acc) * 64'd10 + 64'(c - ChZero);
            acc = (next_mag > 64'(MagCap)) ? MagCap : next_mag[AccW-1:0];
          end else begin
            phase = PH_DONE;
          end
        end
      end
      line_len++;
    endfunction

    function void check_setting(logic [TgtW-1:0] t, logic signed [ValueW-1:0] v);
      setting_t e;
      if (expected_settings.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: target %0d value %0d", t, v);
        return;
      end
      e = expected_settings.pop_front();
      settings_checked++;
      if (e.target !== t || e.value !== v) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: expected target %0d value %0d, got target %0d value %0d",
                   settings_checked, e.target, e.value, t, v);
      end else begin
        target_count[e.target]++;
      end
    endfunction

    function void report_leftover();
      setting_t e;
      while (expected_settings.size() != 0) begin
        e = expected_settings.pop_front();
        failures++;
        if (failures <= 10)
          $display("missing result: target %0d value %0d never came", e.target, e.value);
      end
    endfunction

  endclass

endpackage

>>> verif/tb_top.sv
// Top-level testbench for the serial gain command parser.
`timescale 1ns / 1ps

module tb_top;

  import sgcp_pkg::*;
  import gain_parser_check_pkg::*;

  localparam int unsigned LineBytes   = LineBufferBytesDef;
  localparam int unsigned RandomWords = 800;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 1000000;
  localparam logic [CharW-1:0] Blanks [4] = '{ChSpace, ChTab, ChVt, ChFf};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CharW-1:0]         in_rx_char = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [TgtW-1:0]          out_target;
  logic signed [ValueW-1:0] out_value;

  setting_scoreboard sb;
  string             Prefixes [3] = '{"kp=", "kd=", "th="};
  string             ShortPool = "kpdth=";
  logic [CharW-1:0]  line_q[$];
  int unsigned       words_sent = 0;
  int unsigned       cycle_count = 0;
  bit                no_idle = 1'b0;
  bit                hold_request = 1'b0;
  bit                hold_active = 1'b0;

  serial_gain_command_parser #(
    .LINE_BUFFER_BYTES(LineBytes)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_char(in_rx_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_target(out_target),
    .out_value (out_value)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Handshakes are seen here with the values that stood before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_char(in_rx_char);
      if (out_valid && out_ready) sb.check_setting(out_target, out_value);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called and returning at a falling edge.
  task automatic send_word(logic [CharW-1:0] c);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_char <= c;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    words_sent++;
    @(negedge clk);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void add_digits(int unsigned n);
    repeat (n) line_q.push_back(8'(ChZero + $urandom_range(0, 9)));
  endfunction

  task automatic send_queued(logic [CharW-1:0] term);
    foreach (line_q[i]) send_word(line_q[i]);
    send_word(term);
    line_q.delete();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_settings.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed commands with random content; the rest is junk, damaged or odd-length.
  task automatic send_random_line(int unsigned kind);
    int unsigned n;
    int unsigned pos;
    logic [CharW-1:0] term;
    term = $urandom_range(0, 1) ? ChCr : ChLf;
    if (kind < 70) begin
      add_text(Prefixes[$urandom_range(0, 2)]);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) line_q.push_back(Blanks[$urandom_range(0, 3)]);
      case ($urandom_range(0, 2))
        1: line_q.push_back(ChPlus);
        2: line_q.push_back(ChMinus);
        default: ;
      endcase
      n = $urandom_range(0, 99);
      if (n < 8) begin
        // No digits at all.
      end else if (n < 20) begin
        add_text("214748364");
        line_q.push_back(8'(ChZero + $urandom_range(6, 9)));
      end else if (n < 32) begin
        add_digits($urandom_range(11, 16));
      end else begin
        add_digits($urandom_range(1, 6));
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 88) begin
      add_text(Prefixes[$urandom_range(0, 2)]);
      add_digits($urandom_range(1, 5));
      pos = $urandom_range(0, line_q.size() - 1);
      line_q[pos] = $urandom_range(0, 1) ? ChNul : 8'($urandom_range(0, 255));
    end else if (kind < 95) begin
      add_text(Prefixes[$urandom_range(0, 2)]);
      add_digits($urandom_range(25, 40));
    end else begin
      repeat ($urandom_range(0, 2)) line_q.push_back(ShortPool[$urandom_range(0, 5)]);
    end
    send_queued(term);
  endtask

  // Output side: random stalls, a quiet mode, and one long hold-off on request.
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_active = 1'b1;
        out_ready <= 1'b0;
        for (int held = 0; held < HoldCycles; held++) @(negedge clk);
        hold_active = 1'b0;
        hold_request = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(negedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned random_start;
    bit hold_done;
    bit drain_done;
    hold_done = 1'b0;
    drain_done = 1'b0;
    sb = new(LineBytes);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_text("kp=0");            send_queued(ChLf);
    add_text("kd=-2147483648");  send_queued(ChCr);
    add_text("th=2147483647");   send_queued(ChLf);
    add_text("kp=99999999999");  send_queued(ChLf);
    add_text("kd=-99999999999"); send_queued(ChCr);
    add_text("th=");
    line_q.push_back(ChSpace);
    line_q.push_back(ChTab);
    line_q.push_back(ChVt);
    line_q.push_back(ChFf);
    add_text("+42x7");           send_queued(ChLf);
    add_text("kp=-");            send_queued(ChLf);
    add_text("kd=");             send_queued(ChLf);
    add_text("th=abc");          send_queued(ChLf);
    add_text("k");               send_queued(ChLf);
    send_queued(ChCr);
    add_text("ab=5");            send_queued(ChLf);
    add_text("tp=1");            send_queued(ChLf);
    add_text("k");
    line_q.push_back(ChNul);
    add_text("=5");              send_queued(ChLf);
    add_text("kp=1");
    line_q.push_back(ChNul);
    add_text("23");              send_queued(ChLf);
    add_text("kd=12 34");        send_queued(ChLf);
    add_text("th=");
    line_q.push_back(8'hFF);
    add_text("7");               send_queued(ChLf);
    // Thirty words and a line end still fit in the buffer.
    add_text("kp=123456789012345678901234567");  send_queued(ChLf);
    // Thirty-one words fill the buffer, so the line end is dropped.
    add_text("th=9999999999999999999999999999"); send_queued(ChLf);
    add_text("kd=5");            send_queued(ChLf);

    random_start = words_sent;
    while (words_sent < random_start + RandomWords) begin
      no_idle = (words_sent >= random_start + 150) && (words_sent < random_start + 250);
      if (!hold_done && words_sent >= random_start + 400) begin
        hold_done = 1'b1;
        hold_request = 1'b1;
        wait (hold_active);
        repeat (8) send_random_line(0);
      end else if (!drain_done && words_sent >= random_start + 700) begin
        drain_done = 1'b1;
        drain_results();
      end else begin
        send_random_line($urandom_range(0, 99));
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (8) @(negedge clk);
    sb.report_leftover();
    $display("Fed %0d words, checked %0d settings (kp %0d, kd %0d, th %0d), %0d at limits.",
             sb.chars_noted, sb.settings_checked, sb.target_count[0], sb.target_count[1],
             sb.target_count[2], sb.limit_values);
    $display("Lines mixed signs, blanks, junk, NUL words, short and overlong lines under stalls.");
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sgcp_pkg.sv
rtl/core/sgcp_step.sv
rtl/core/serial_gain_command_parser.sv
rtl/core/sgcp_checker.sv
verif/gain_parser_check_pkg.sv
verif/tb_top.sv
